// ===== rtl/esip_pkg.sv =====
`timescale 1ns / 1ps

package esip_pkg;

  localparam int FRAC_BITS_DEF   = 8;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam int COEF_W  = 16;
  localparam int SCALE_W = 16;
  localparam int STEP_W  = 3;
  localparam int SPEED_W = 16;
  localparam int ERR_W   = 18;
  localparam int ACC_W   = 32;
  localparam int DUTY_W  = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int MUL_B_W    = COEF_W + 1;

  localparam logic [CFG_IDX_W-1:0] CFG_COEF_Q0     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_Q1     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_Q2     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SCALE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT_DIR  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_STEP  = 3'd5;

  localparam logic signed [COEF_W-1:0] COEF_Q0_RST = 16'sd1574;
  localparam logic signed [COEF_W-1:0] COEF_Q1_RST = -16'sd2688;
  localparam logic signed [COEF_W-1:0] COEF_Q2_RST = 16'sd1152;
  localparam logic [SCALE_W-1:0]       SCALE_RST   = 16'd206;
  localparam logic                     INVERT_RST  = 1'b1;
  localparam logic [STEP_W-1:0]        STEP_RST    = 3'd1;

  localparam logic OP_EDGE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic                      opcode;
    logic                      phase_a;
    logic                      phase_b;
    logic signed [SPEED_W-1:0] target_speed;
  } esip_in_t;

  typedef struct packed {
    logic [DUTY_W-1:0]         drive_duty;
    logic signed [SPEED_W-1:0] measured_speed;
  } esip_out_t;

  typedef struct packed {
    logic step_en;
    logic up;
    logic clear;
  } esip_cnt_ctl_t;

endpackage

// ===== rtl/esip_mul.sv =====
`timescale 1ns / 1ps

module esip_mul #(
  parameter int AW = 18
) (
  input  logic                                     clk,
  input  logic signed [AW-1:0]                     mul_a,
  input  logic signed [esip_pkg::MUL_B_W-1:0]      mul_b,
  output logic signed [AW+esip_pkg::MUL_B_W-1:0]   prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

endmodule

// ===== rtl/esip_edge_cnt.sv =====
`timescale 1ns / 1ps

module esip_edge_cnt #(
  parameter int COUNT_WIDTH = esip_pkg::COUNT_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  esip_pkg::esip_cnt_ctl_t           ctl,
  input  logic [esip_pkg::STEP_W-1:0]       step,
  output logic signed [COUNT_WIDTH-1:0]     cnt_r
);

  localparam logic signed [COUNT_WIDTH:0] CMAX = {2'b00, {(COUNT_WIDTH-1){1'b1}}};
  localparam logic signed [COUNT_WIDTH:0] CMIN = {2'b11, {(COUNT_WIDTH-1){1'b0}}};

  logic signed [COUNT_WIDTH:0]   step_w;
  logic signed [COUNT_WIDTH:0]   sum_w;
  logic signed [COUNT_WIDTH-1:0] cnt_nxt;

  always_comb begin
    step_w = signed'((COUNT_WIDTH+1)'(step));
    sum_w  = ctl.up ? (COUNT_WIDTH+1)'(cnt_r) + step_w : (COUNT_WIDTH+1)'(cnt_r) - step_w;
    cnt_nxt = cnt_r;
    if (ctl.clear) begin
      cnt_nxt = '0;
    end else if (ctl.step_en) begin
      if (sum_w > CMAX) begin
        cnt_nxt = CMAX[COUNT_WIDTH-1:0];
      end else if (sum_w < CMIN) begin
        cnt_nxt = CMIN[COUNT_WIDTH-1:0];
      end else begin
        cnt_nxt = sum_w[COUNT_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/encoder_speed_incremental_pid.sv =====
`timescale 1ns / 1ps

// One motor channel: quadrature edge counter plus incremental PID speed loop in
// signed fixed point with FRAC_BITS fraction bits. An edge request is taken
// while the block is idle and gives no result. A tick request occupies the block
// for the accept plus 7 sequencer steps, longer only while a previous result is still
// held in the output register; the steps are set by the single registered
// multiplier, used four times per tick (count times scale, then the three PID
// terms). in_stall stays high for the whole tick. The output register lets a
// new request enter while a finished result waits on out_stall.
module encoder_speed_incremental_pid #(
  parameter int FRAC_BITS   = esip_pkg::FRAC_BITS_DEF,
  parameter int COUNT_WIDTH = esip_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  esip_pkg::esip_in_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output esip_pkg::esip_out_t                  out_data,
  input  logic                                 cfg_wr_en,
  input  logic [esip_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [esip_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int AW = (COUNT_WIDTH > esip_pkg::ERR_W) ? COUNT_WIDTH : esip_pkg::ERR_W;
  localparam int PW = AW + esip_pkg::MUL_B_W;
  localparam int SW = PW + 2;
  localparam int UW = SW + 1;
  localparam int AW_ACC = esip_pkg::ACC_W;

  localparam logic signed [AW_ACC-1:0] UTOP = AW_ACC'(128) << FRAC_BITS;
  localparam logic signed [UW-1:0]     UTOP_W = UW'(UTOP);
  localparam logic signed [UW-1:0]     IMIN_W = UW'(-64'sd2147483648);
  localparam logic signed [AW_ACC:0]   RND = (AW_ACC+1)'((64'sd1 << FRAC_BITS) - 64'sd1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SPD  = 3'd1;
  localparam logic [2:0] S_ERR  = 3'd2;
  localparam logic [2:0] S_M0   = 3'd3;
  localparam logic [2:0] S_M1   = 3'd4;
  localparam logic [2:0] S_M2   = 3'd5;
  localparam logic [2:0] S_ADD  = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic signed [esip_pkg::COEF_W-1:0]  q0_r, q1_r, q2_r;
  logic [esip_pkg::SCALE_W-1:0]        scale_r;
  logic                                invert_r;
  logic [esip_pkg::STEP_W-1:0]         step_r;

  logic [2:0]                          state_r, state_nxt;
  logic signed [esip_pkg::SPEED_W-1:0] tgt_speed_r;
  logic signed [esip_pkg::SPEED_W-1:0] speed_r;
  logic signed [esip_pkg::ERR_W-1:0]   err_r, e1_r, e2_r;
  logic signed [AW_ACC-1:0]            accum_r;
  logic signed [SW-1:0]                sum_r;
  logic                                out_valid_r;
  esip_pkg::esip_out_t                 out_data_r;

  logic                                in_take;
  logic                                fin_load;
  esip_pkg::esip_cnt_ctl_t             cnt_ctl;
  logic signed [COUNT_WIDTH-1:0]       cnt;
  logic signed [AW-1:0]                mul_a;
  logic signed [esip_pkg::MUL_B_W-1:0] mul_b;
  logic signed [PW-1:0]                prod_r;

  logic signed [PW-1:0]                spd_sh;
  logic signed [PW:0]                  spd_w;
  logic signed [esip_pkg::SPEED_W-1:0] speed_c;
  logic signed [esip_pkg::ERR_W-1:0]   err_c;
  logic signed [SW-1:0]                sum_sh;
  logic signed [UW-1:0]                u_w;
  logic signed [AW_ACC-1:0]            u_c;
  logic signed [AW_ACC:0]              u_b;
  logic signed [AW_ACC:0]              whole;
  logic [esip_pkg::DUTY_W-1:0]         duty_c;

  assign in_stall  = (state_r != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign fin_load  = (state_r == S_FIN) && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q0_r     <= esip_pkg::COEF_Q0_RST;
      q1_r     <= esip_pkg::COEF_Q1_RST;
      q2_r     <= esip_pkg::COEF_Q2_RST;
      scale_r  <= esip_pkg::SCALE_RST;
      invert_r <= esip_pkg::INVERT_RST;
      step_r   <= esip_pkg::STEP_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        esip_pkg::CFG_COEF_Q0:     q0_r     <= cfg_wdata;
        esip_pkg::CFG_COEF_Q1:     q1_r     <= cfg_wdata;
        esip_pkg::CFG_COEF_Q2:     q2_r     <= cfg_wdata;
        esip_pkg::CFG_SPEED_SCALE: scale_r  <= cfg_wdata;
        esip_pkg::CFG_INVERT_DIR:  invert_r <= cfg_wdata[0];
        esip_pkg::CFG_COUNT_STEP:  step_r   <= cfg_wdata[esip_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cnt_ctl.step_en = in_take && (in_data.opcode == esip_pkg::OP_EDGE);
    cnt_ctl.up      = (in_data.phase_a == in_data.phase_b);
    cnt_ctl.clear   = fin_load;
  end

  esip_edge_cnt #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_cnt (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (cnt_ctl),
    .step  (step_r),
    .cnt_r (cnt)
  );

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_SPD: begin
        mul_a = AW'(cnt);
        mul_b = signed'(esip_pkg::MUL_B_W'(scale_r));
      end
      S_M0: begin
        mul_a = AW'(err_r);
        mul_b = esip_pkg::MUL_B_W'(q0_r);
      end
      S_M1: begin
        mul_a = AW'(e1_r);
        mul_b = esip_pkg::MUL_B_W'(q1_r);
      end
      S_M2: begin
        mul_a = AW'(e2_r);
        mul_b = esip_pkg::MUL_B_W'(q2_r);
      end
      default: ;
    endcase
  end

  esip_mul #(
    .AW(AW)
  ) u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod_r)
  );

  // speed and error
  always_comb begin
    spd_sh = prod_r >>> FRAC_BITS;
    spd_w  = (PW+1)'(spd_sh);
    if (invert_r) begin
      spd_w = -spd_w;
    end
    if (spd_w > (PW+1)'(32767)) begin
      speed_c = 16'sh7fff;
    end else if (spd_w < (PW+1)'(-32768)) begin
      speed_c = 16'sh8000;
    end else begin
      speed_c = spd_w[esip_pkg::SPEED_W-1:0];
    end
    err_c = esip_pkg::ERR_W'(tgt_speed_r) - esip_pkg::ERR_W'(speed_c);
  end

  // accumulator update and duty
  always_comb begin
    sum_sh = sum_r >>> FRAC_BITS;
    u_w    = UW'(accum_r) + UW'(sum_sh);
    if (u_w > UTOP_W) begin
      u_c = UTOP;
    end else if (u_w < IMIN_W) begin
      u_c = IMIN_W[AW_ACC-1:0];
    end else begin
      u_c = u_w[AW_ACC-1:0];
    end
    u_b = (AW_ACC+1)'(u_c);
    if (u_c < 0) begin
      u_b = u_b + RND;
    end
    whole = u_b >>> FRAC_BITS;
    if (whole > (AW_ACC+1)'(127)) begin
      duty_c = 8'd255;
    end else if (whole < (AW_ACC+1)'(-128)) begin
      duty_c = 8'd0;
    end else begin
      duty_c = esip_pkg::DUTY_W'(whole + (AW_ACC+1)'(128));
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_take && (in_data.opcode == esip_pkg::OP_TICK)) begin
        state_nxt = S_SPD;
      end
      S_SPD: state_nxt = S_ERR;
      S_ERR: state_nxt = S_M0;
      S_M0:  state_nxt = S_M1;
      S_M1:  state_nxt = S_M2;
      S_M2:  state_nxt = S_ADD;
      S_ADD: state_nxt = S_FIN;
      S_FIN: if (fin_load) begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      accum_r     <= '0;
      e1_r        <= '0;
      e2_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= fin_load || (out_valid_r && out_stall);
      if (fin_load) begin
        accum_r <= u_c;
        e1_r    <= err_r;
        e2_r    <= e1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      tgt_speed_r <= in_data.target_speed;
    end
    if (state_r == S_ERR) begin
      speed_r <= speed_c;
      err_r   <= err_c;
    end
    if (state_r == S_M1) begin
      sum_r <= SW'(prod_r);
    end else if ((state_r == S_M2) || (state_r == S_ADD)) begin
      sum_r <= sum_r + SW'(prod_r);
    end
    if (fin_load) begin
      out_data_r.drive_duty     <= duty_c;
      out_data_r.measured_speed <= speed_r;
    end
  end

`ifndef SYNTHESIS
  a_tick_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && (in_data.opcode == esip_pkg::OP_TICK)) |=> (state_r == S_SPD))
    else $error("tick request did not start the sequencer");

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result raised outside the final step");

  a_accum_top: assert property (@(posedge clk) disable iff (!rst_n)
    accum_r <= UTOP)
    else $error("accumulator above upper clamp");

  a_cnt_clear: assert property (@(posedge clk) disable iff (!rst_n)
    fin_load |=> (cnt == '0))
    else $error("edge count not cleared after tick");

  a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_data_r)))
    else $error("held result lost or changed");
`endif

endmodule

// ===== tb/encoder_speed_incremental_pid_tb.sv =====
`timescale 1ns / 1ps

module encoder_speed_incremental_pid_tb;

  localparam int     FRAC       = esip_pkg::FRAC_BITS_DEF;
  localparam longint COUNT_MAX  = (longint'(1) <<< (esip_pkg::COUNT_WIDTH_DEF - 1)) - 1;
  localparam longint COUNT_MIN  = -COUNT_MAX - 1;
  localparam longint SPEED_MAX  = (longint'(1) <<< (esip_pkg::SPEED_W - 1)) - 1;
  localparam longint SPEED_MIN  = -SPEED_MAX - 1;
  localparam longint ACC_MAX    = (longint'(1) <<< (esip_pkg::ACC_W - 1)) - 1;
  localparam longint ACC_MIN    = -ACC_MAX - 1;
  localparam longint U_CEIL     = longint'(128) <<< FRAC;
  localparam longint DUTY_MID   = 128;
  localparam longint DUTY_MAX   = (longint'(1) <<< esip_pkg::DUTY_W) - 1;

  localparam logic [esip_pkg::CFG_IDX_W-1:0] CFG_SPARE6 = 3'd6;
  localparam logic [esip_pkg::CFG_IDX_W-1:0] CFG_SPARE7 = 3'd7;

  localparam int LONG_HOLD      = 300;
  localparam int SETTLE         = 12;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int EDGE_RUN       = 40;

  typedef struct {
    esip_pkg::esip_in_t  req;
    bit                  typed;
    esip_pkg::esip_out_t want;
  } plan_row_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_stall;
  esip_pkg::esip_in_t              in_data;
  logic                            out_valid;
  logic                            out_stall;
  esip_pkg::esip_out_t             out_data;
  logic                            cfg_wr_en;
  logic [esip_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [esip_pkg::CFG_DATA_W-1:0] cfg_wdata;

  encoder_speed_incremental_pid dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state and settings
  logic signed [esip_pkg::COUNT_WIDTH_DEF-1:0] edge_tally;
  logic signed [esip_pkg::ACC_W-1:0]           drive_u;
  logic signed [esip_pkg::ERR_W-1:0]           err_prev;
  logic signed [esip_pkg::ERR_W-1:0]           err_prev2;
  logic signed [esip_pkg::COEF_W-1:0]          q0_r;
  logic signed [esip_pkg::COEF_W-1:0]          q1_r;
  logic signed [esip_pkg::COEF_W-1:0]          q2_r;
  logic [esip_pkg::SCALE_W-1:0]                scale_r;
  logic                                        invert_r;
  logic [esip_pkg::STEP_W-1:0]                 step_r;

  esip_pkg::esip_out_t drive_due_q[$];
  plan_row_t           typed_q[$];
  esip_pkg::esip_out_t predicted;
  esip_pkg::esip_out_t due;
  plan_row_t           note;
  plan_row_t           plan [18];

  int fault_count  = 0;
  int idle_cycles  = 0;
  bit calm         = 1'b0;
  bit hold_off_req = 1'b0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void count_edge(input esip_pkg::esip_in_t req);
    longint tally;
    tally = edge_tally;
    if (req.phase_a == req.phase_b) begin
      tally = tally + longint'(step_r);
    end else begin
      tally = tally - longint'(step_r);
    end
    tally = clip(tally, COUNT_MIN, COUNT_MAX);
    edge_tally = tally[esip_pkg::COUNT_WIDTH_DEF-1:0];
  endfunction

  function automatic esip_pkg::esip_out_t close_speed_loop(input esip_pkg::esip_in_t req);
    longint              speed;
    longint              err;
    longint              sum;
    longint              u;
    longint              whole;
    longint              duty;
    esip_pkg::esip_out_t res;
    speed = (longint'(edge_tally) * longint'(scale_r)) >>> FRAC;
    if (invert_r) speed = -speed;
    speed = clip(speed, SPEED_MIN, SPEED_MAX);
    err = longint'($signed(req.target_speed)) - speed;
    sum = longint'(q0_r) * err + longint'(q1_r) * longint'(err_prev)
        + longint'(q2_r) * longint'(err_prev2);
    u = clip(longint'(drive_u) + (sum >>> FRAC), ACC_MIN, ACC_MAX);
    if (u > U_CEIL) u = U_CEIL;
    drive_u = u[esip_pkg::ACC_W-1:0];
    err_prev2 = err_prev;
    err_prev = err[esip_pkg::ERR_W-1:0];
    whole = (u >= 0) ? (u >>> FRAC) : -((-u) >>> FRAC);
    duty = clip(DUTY_MID + whole, 0, DUTY_MAX);
    res.drive_duty = duty[esip_pkg::DUTY_W-1:0];
    res.measured_speed = speed[esip_pkg::SPEED_W-1:0];
    edge_tally = '0;
    return res;
  endfunction

  function automatic plan_row_t plan_row(input logic op, input logic a, input logic b,
                                         input int target, input bit typed = 1'b0,
                                         input int duty = 0, input int spd = 0);
    plan_row_t r;
    r.req.opcode = op;
    r.req.phase_a = a;
    r.req.phase_b = b;
    r.req.target_speed = target[esip_pkg::SPEED_W-1:0];
    r.typed = typed;
    r.want.drive_duty = duty[esip_pkg::DUTY_W-1:0];
    r.want.measured_speed = spd[esip_pkg::SPEED_W-1:0];
    return r;
  endfunction

  function automatic int draw_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int draw_target();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return ($urandom_range(0, 1) != 0) ? 32767 : -32768;
    if (r < 55) return int'($urandom_range(0, 4000)) - 2000;
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic logic [esip_pkg::CFG_DATA_W-1:0] draw_coef();
    int v;
    v = int'($urandom_range(0, 6000)) - 3000;
    if ($urandom_range(0, 3) == 0) v = int'($urandom_range(0, 65535));
    return v[esip_pkg::CFG_DATA_W-1:0];
  endfunction

  function automatic logic [esip_pkg::CFG_DATA_W-1:0] draw_scale();
    if ($urandom_range(0, 3) == 0) return esip_pkg::CFG_DATA_W'($urandom_range(0, 65535));
    return esip_pkg::CFG_DATA_W'($urandom_range(0, 1200));
  endfunction

  function automatic esip_pkg::esip_in_t edge_req(input bit up);
    esip_pkg::esip_in_t req;
    req.opcode = esip_pkg::OP_EDGE;
    req.phase_a = 1'($urandom_range(0, 1));
    req.phase_b = up ? req.phase_a : ~req.phase_a;
    req.target_speed = esip_pkg::SPEED_W'($urandom_range(0, 65535));
    return req;
  endfunction

  function automatic esip_pkg::esip_in_t tick_req(input int target);
    esip_pkg::esip_in_t req;
    req.opcode = esip_pkg::OP_TICK;
    req.phase_a = 1'($urandom_range(0, 1));
    req.phase_b = 1'($urandom_range(0, 1));
    req.target_speed = target[esip_pkg::SPEED_W-1:0];
    return req;
  endfunction

  task automatic send_req(input esip_pkg::esip_in_t req);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (drive_due_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [esip_pkg::CFG_IDX_W-1:0] idx,
                           input logic [esip_pkg::CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic load_settings(input logic [esip_pkg::CFG_DATA_W-1:0] q0, q1, q2, scale,
                               input logic inv, input logic [esip_pkg::STEP_W-1:0] stp);
    logic [esip_pkg::CFG_DATA_W-1:0] junk;
    junk = esip_pkg::CFG_DATA_W'($urandom);
    wait_drained();
    write_reg(esip_pkg::CFG_COEF_Q0, q0);
    write_reg(esip_pkg::CFG_COEF_Q1, q1);
    write_reg(esip_pkg::CFG_COEF_Q2, q2);
    write_reg(esip_pkg::CFG_SPEED_SCALE, scale);
    write_reg(esip_pkg::CFG_INVERT_DIR, {junk[esip_pkg::CFG_DATA_W-1:1], inv});
    write_reg(esip_pkg::CFG_COUNT_STEP,
              {junk[esip_pkg::CFG_DATA_W-1:esip_pkg::STEP_W], stp});
    write_reg(CFG_SPARE6, junk);
    write_reg(CFG_SPARE7, ~junk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_random(input int n_items);
    int                 sent;
    int                 burst;
    bit                 up;
    esip_pkg::esip_in_t req;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 85) begin
        burst = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 12) : $urandom_range(13, 60);
        up = 1'($urandom_range(0, 1));
        repeat (burst) begin
          // flip an occasional edge against the travel
          send_req(edge_req(($urandom_range(0, 9) == 0) ? !up : up));
          sent++;
        end
        send_req(tick_req(draw_target()));
        sent++;
      end else begin
        req = tick_req(draw_target());
        req.opcode = 1'($urandom_range(0, 1));
        send_req(req);
        sent++;
      end
    end
  endtask

  task automatic drive_to_limits();
    load_settings(16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 1'b0, 3'd7);
    repeat (EDGE_RUN) send_req(edge_req(1'b1));
    send_req(tick_req(-32768));
    repeat (EDGE_RUN) send_req(edge_req(1'b0));
    send_req(tick_req(32767));
    // wind the accumulator down to its lower limit
    repeat (200) send_req(tick_req(32767));
    repeat (4) send_req(tick_req(-32768));
  endtask

  // predict and check
  always @(posedge clk) begin
    if (!rst_n) begin
      edge_tally = '0;
      drive_u = '0;
      err_prev = '0;
      err_prev2 = '0;
      q0_r = esip_pkg::COEF_Q0_RST;
      q1_r = esip_pkg::COEF_Q1_RST;
      q2_r = esip_pkg::COEF_Q2_RST;
      scale_r = esip_pkg::SCALE_RST;
      invert_r = esip_pkg::INVERT_RST;
      step_r = esip_pkg::STEP_RST;
    end else begin
      if (out_valid && !out_stall) begin
        if (drive_due_q.size() == 0) begin
          $error("unexpected result: drive_duty %0d measured_speed %0d",
                 out_data.drive_duty, $signed(out_data.measured_speed));
          fault_count++;
        end else begin
          due = drive_due_q.pop_front();
          if (out_data.drive_duty !== due.drive_duty) begin
            $error("drive_duty: expected %0d, got %0d", due.drive_duty, out_data.drive_duty);
            fault_count++;
          end
          if (out_data.measured_speed !== due.measured_speed) begin
            $error("measured_speed: expected %0d, got %0d",
                   $signed(due.measured_speed), $signed(out_data.measured_speed));
            fault_count++;
          end
        end
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          esip_pkg::CFG_COEF_Q0:     q0_r = cfg_wdata;
          esip_pkg::CFG_COEF_Q1:     q1_r = cfg_wdata;
          esip_pkg::CFG_COEF_Q2:     q2_r = cfg_wdata;
          esip_pkg::CFG_SPEED_SCALE: scale_r = cfg_wdata;
          esip_pkg::CFG_INVERT_DIR:  invert_r = cfg_wdata[0];
          esip_pkg::CFG_COUNT_STEP:  step_r = cfg_wdata[esip_pkg::STEP_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (in_data.opcode == esip_pkg::OP_EDGE) begin
          count_edge(in_data);
        end else begin
          predicted = close_speed_loop(in_data);
          if (typed_q.size() > 0) begin
            note = typed_q.pop_front();
            if (note.typed) predicted = note.want;
          end
          drive_due_q.push_back(predicted);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_wr_en || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side backpressure
  initial begin
    int hold;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold = LONG_HOLD;
      end else begin
        hold = draw_gap();
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_wr_en <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    plan = '{
      plan_row(esip_pkg::OP_TICK, 0, 0, 0, 1'b1, 128, 0),
      plan_row(esip_pkg::OP_TICK, 0, 0, 32767, 1'b1, 255, 0),
      plan_row(esip_pkg::OP_EDGE, 0, 0, -32768),
      plan_row(esip_pkg::OP_EDGE, 1, 1, 32767),
      plan_row(esip_pkg::OP_EDGE, 0, 1, 21845),
      plan_row(esip_pkg::OP_EDGE, 1, 0, -21846),
      plan_row(esip_pkg::OP_EDGE, 1, 1, 0),
      plan_row(esip_pkg::OP_EDGE, 0, 0, -1),
      plan_row(esip_pkg::OP_TICK, 1, 1, -32768),
      plan_row(esip_pkg::OP_TICK, 0, 1, 32767),
      plan_row(esip_pkg::OP_EDGE, 0, 1, 0),
      plan_row(esip_pkg::OP_EDGE, 1, 0, 0),
      plan_row(esip_pkg::OP_EDGE, 0, 1, 0),
      plan_row(esip_pkg::OP_TICK, 1, 0, 0),
      plan_row(esip_pkg::OP_TICK, 0, 0, -1),
      plan_row(esip_pkg::OP_TICK, 1, 1, 21845),
      plan_row(esip_pkg::OP_EDGE, 1, 0, -21846),
      plan_row(esip_pkg::OP_TICK, 0, 1, 1)
    };
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].req.opcode == esip_pkg::OP_TICK) typed_q.push_back(plan[i]);
      send_req(plan[i].req);
    end

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: load_settings(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 1'b0, 3'd7);
        1: load_settings(16'h8000, 16'h8000, 16'h8000, 16'h0000, 1'b1, 3'd0);
        2: load_settings(esip_pkg::COEF_Q0_RST, esip_pkg::COEF_Q1_RST,
                         esip_pkg::COEF_Q2_RST, esip_pkg::SCALE_RST,
                         esip_pkg::INVERT_RST, esip_pkg::STEP_RST);
        default: load_settings(draw_coef(), draw_coef(), draw_coef(), draw_scale(),
                               1'($urandom_range(0, 1)),
                               esip_pkg::STEP_W'($urandom_range(0, 7)));
      endcase
      calm = (ph == 5);
      if (ph == 3) begin
        hold_off_req = 1'b1;
        repeat (6) send_req(tick_req(draw_target()));
      end
      run_random(24);
    end
    calm = 1'b0;

    drive_to_limits();
    wait_drained();
    @(negedge clk);
    if (fault_count == 0 && drive_due_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
